// ===== design/uerc_pkg.sv =====
`timescale 1ns / 1ps

package uerc_pkg;

    localparam int COUNT_WIDTH = 16;

    // widths used for limit compares and output saturation
    localparam int CMP_W   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int PROD_W  = COUNT_WIDTH + 24;
    localparam int SHIFT_W = PROD_W - 16;
    localparam int DIST_CW = (SHIFT_W > 24) ? SHIFT_W : 24;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;
    localparam logic [23:0] DIST_MAX  = 24'hFFFFFF;

    localparam logic [15:0] SETTLE_RESET  = 16'd50000;
    localparam logic [15:0] TRIGGER_RESET = 16'd100;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [23:0] SCALE_RESET   = 24'd368737;

    typedef logic [1:0] cfg_idx_t;

    localparam cfg_idx_t REG_SETTLE  = 2'd0;
    localparam cfg_idx_t REG_TRIGGER = 2'd1;
    localparam cfg_idx_t REG_TIMEOUT = 2'd2;
    localparam cfg_idx_t REG_SCALE   = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SETTLE  = 3'd1,
        PH_TRIGGER = 3'd2,
        PH_RISE    = 3'd3,
        PH_FALL    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [15:0] trigger_ticks;
        logic [15:0] echo_timeout;
        logic [23:0] distance_scale;
    } cfg_t;

    typedef struct packed {
        logic   sensor_power;
        logic   trigger_level;
        logic   busy;
        logic   done;
        logic   timed_out;
        logic   measured;
        count_t echo_count;
    } seq_res_t;

    function automatic count_t sat_inc(count_t c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + count_t'(1);
    endfunction

    // a saturated count has reached any limit
    function automatic logic reached(count_t c, logic [15:0] limit);
        logic [CMP_W-1:0] cw;
        logic [CMP_W-1:0] lw;
        cw = CMP_W'(c);
        lw = CMP_W'(limit);
        return (cw >= lw) || (c == COUNT_MAX);
    endfunction

    function automatic logic expired(count_t c, logic [15:0] limit);
        logic [CMP_W-1:0] cw;
        logic [CMP_W-1:0] lw;
        cw = CMP_W'(c);
        lw = CMP_W'(limit);
        return (cw > lw) || (c == COUNT_MAX);
    endfunction

endpackage

// ===== design/uerc_cfg_regs.sv =====
`timescale 1ns / 1ps

module uerc_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  uerc_pkg::cfg_idx_t wr_index,
    input  logic [23:0]        wr_data,
    output uerc_pkg::cfg_t     cfg
);
    import uerc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_SETTLE:  cfg_next.settle_ticks   = wr_data[15:0];
                REG_TRIGGER: cfg_next.trigger_ticks  = wr_data[15:0];
                REG_TIMEOUT: cfg_next.echo_timeout   = wr_data[15:0];
                REG_SCALE:   cfg_next.distance_scale = wr_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks   <= SETTLE_RESET;
            cfg_reg.trigger_ticks  <= TRIGGER_RESET;
            cfg_reg.echo_timeout   <= TIMEOUT_RESET;
            cfg_reg.distance_scale <= SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/uerc_seq.sv =====
`timescale 1ns / 1ps

module uerc_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               func,
    input  logic               echo_level,
    input  uerc_pkg::cfg_t     cfg,
    output uerc_pkg::seq_res_t res
);
    import uerc_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    count_t phase_count_reg;
    count_t phase_count_next;
    count_t timeout_count_reg;
    count_t timeout_count_next;
    count_t echo_count_reg;
    count_t echo_count_next;

    count_t phase_inc;
    count_t timeout_inc;
    logic   done;
    logic   timed_out;
    logic   measured;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            phase_count_reg   <= '0;
            timeout_count_reg <= '0;
            echo_count_reg    <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            phase_count_reg   <= phase_count_next;
            timeout_count_reg <= timeout_count_next;
            echo_count_reg    <= echo_count_next;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        phase_count_next   = phase_count_reg;
        timeout_count_next = timeout_count_reg;
        echo_count_next    = echo_count_reg;
        phase_inc          = sat_inc(phase_count_reg);
        timeout_inc        = sat_inc(timeout_count_reg);
        done               = 1'b0;
        timed_out          = 1'b0;
        measured           = 1'b0;

        if (step)
        begin
            if (func)
            begin
                // start is dropped while a measurement runs
                if (phase_reg == PH_IDLE)
                begin
                    phase_next       = PH_SETTLE;
                    phase_count_next = '0;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_SETTLE:
                    begin
                        phase_count_next = phase_inc;
                        if (reached(phase_inc, cfg.settle_ticks))
                        begin
                            phase_next       = PH_TRIGGER;
                            phase_count_next = '0;
                        end
                    end
                    PH_TRIGGER:
                    begin
                        phase_count_next = phase_inc;
                        if (reached(phase_inc, cfg.trigger_ticks))
                        begin
                            phase_next         = PH_RISE;
                            timeout_count_next = '0;
                        end
                    end
                    PH_RISE, PH_FALL:
                    begin
                        timeout_count_next = timeout_inc;
                        // timeout wins over the echo level on the same tick
                        if (expired(timeout_inc, cfg.echo_timeout))
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            timed_out  = 1'b1;
                        end
                        else if (phase_reg == PH_RISE)
                        begin
                            if (echo_level)
                            begin
                                phase_next      = PH_FALL;
                                echo_count_next = count_t'(1);
                            end
                        end
                        else if (echo_level)
                        begin
                            echo_count_next = sat_inc(echo_count_reg);
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            measured   = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign res.sensor_power  = (phase_next != PH_IDLE);
    assign res.trigger_level = (phase_next == PH_TRIGGER);
    assign res.busy          = (phase_next != PH_IDLE);
    assign res.done          = done;
    assign res.timed_out     = timed_out;
    assign res.measured      = measured;
    assign res.echo_count    = echo_count_reg;

endmodule

// ===== design/uerc_range.sv =====
`timescale 1ns / 1ps

module uerc_range (
    input  uerc_pkg::seq_res_t res,
    input  logic [23:0]        distance_scale,
    output logic [15:0]        echo_ticks,
    output logic [23:0]        distance_mft
);
    import uerc_pkg::*;

    logic [PROD_W-1:0]  product;
    logic [SHIFT_W-1:0] shifted;
    logic [DIST_CW-1:0] dist_wide;
    logic [CMP_W-1:0]   ticks_wide;

    always_comb
    begin
        product    = PROD_W'(res.echo_count) * PROD_W'(distance_scale);
        shifted    = product[PROD_W-1:16];
        dist_wide  = DIST_CW'(shifted);
        ticks_wide = CMP_W'(res.echo_count);

        if (res.measured)
        begin
            echo_ticks   = (ticks_wide > CMP_W'(TICKS_MAX)) ? TICKS_MAX : ticks_wide[15:0];
            distance_mft = (dist_wide > DIST_CW'(DIST_MAX)) ? DIST_MAX : dist_wide[23:0];
        end
        else
        begin
            echo_ticks   = '0;
            distance_mft = '0;
        end
    end

endmodule

// ===== design/ultrasonic_echo_ranging_controller.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// in      | sink      | in_valid/in_ready   | func, echo_level
// out     | source    | out_valid/out_ready | sensor_power .. distance_mft
// cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each transaction passes the input register, then sequencer, multiply and saturation
// into the result register. One transaction per cycle while out_ready is high.
// Reset returns the phase to idle, clears the counters and loads the register defaults.
// A stalled result holds the result register; the input register still takes one
// more transaction, so in_ready drops only when both stages are full.

module ultrasonic_echo_ranging_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic                 echo_level,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 sensor_power,
    output logic                 trigger_level,
    output logic                 busy_res,
    output logic                 done_res,
    output logic                 timed_out,
    output logic [15:0]          echo_ticks,
    output logic [23:0]          distance_mft,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  uerc_pkg::cfg_idx_t   cfg_index,
    input  logic [23:0]          cfg_data
);
    import uerc_pkg::*;

    cfg_t     cfg;
    seq_res_t res;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        func_reg;
    logic        echo_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        power_reg;
    logic        trigger_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        timed_out_reg;
    logic [15:0] ticks_reg;
    logic [23:0] dist_reg;

    logic        advance;
    logic        step;
    logic        in_take;
    logic [15:0] ticks_calc;
    logic [23:0] dist_calc;

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign cfg_ready = 1'b1;

    uerc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    uerc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .func       (func_reg),
        .echo_level (echo_reg),
        .cfg        (cfg),
        .res        (res)
    );

    uerc_range u_range (
        .res            (res),
        .distance_scale (cfg.distance_scale),
        .echo_ticks     (ticks_calc),
        .distance_mft   (dist_calc)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: load on transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func;
            echo_reg <= echo_level;
        end
        if (step)
        begin
            power_reg     <= res.sensor_power;
            trigger_reg   <= res.trigger_level;
            busy_reg      <= res.busy;
            done_reg      <= res.done;
            timed_out_reg <= res.timed_out;
            ticks_reg     <= ticks_calc;
            dist_reg      <= dist_calc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sensor_power  = power_reg;
    assign trigger_level = trigger_reg;
    assign busy_res      = busy_reg;
    assign done_res      = done_reg;
    assign timed_out     = timed_out_reg;
    assign echo_ticks    = ticks_reg;
    assign distance_mft  = dist_reg;

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (!busy_res && !sensor_power))
        else $error("finished measurement still shows sensor busy");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timed_out) |-> (done_res && echo_ticks == 16'd0 && distance_mft == 24'd0))
        else $error("timeout result carries a distance");

    a_trigger_power: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && trigger_level) |-> (sensor_power && !done_res))
        else $error("trigger driven without sensor power");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while the result side is free");

endmodule
